/* sv/tlqe_pkg.sv */
// Shared types, register codes and vertex order tables for the thick line quad expander.
`default_nettype none
package tlqe_pkg;

  localparam int DATA_W          = 32;
  localparam int HW_W            = 31;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE  = 2'd1;

  localparam logic [HW_W-1:0] HW_RESET   = 31'h0000_8000;
  localparam logic            FILL_RESET = 1'b1;

  localparam logic [2:0] FILL_LAST = 3'd5;
  localparam logic [2:0] EDGE_LAST = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] sx;
    logic [DATA_W-1:0] sy;
    logic [DATA_W-1:0] sz;
    logic [DATA_W-1:0] sc;
    logic [DATA_W-1:0] ex;
    logic [DATA_W-1:0] ey;
    logic [DATA_W-1:0] ez;
    logic [DATA_W-1:0] ec;
  } item_t;

  // Corner emitted at position k: triangles v1 v2 v3 v1 v3 v4, edges v1 v2 v2 v3 v3 v4 v4 v1.
  function automatic logic [1:0] seq_corner(input logic fill, input logic [2:0] k);
    logic [1:0] c;
    c = 2'd0;
    if (fill) begin
      unique case (k)
        3'd0: c = 2'd0;
        3'd1: c = 2'd1;
        3'd2: c = 2'd2;
        3'd3: c = 2'd0;
        3'd4: c = 2'd2;
        3'd5: c = 2'd3;
        default: c = 2'd0;
      endcase
    end else begin
      unique case (k)
        3'd0: c = 2'd0;
        3'd1: c = 2'd1;
        3'd2: c = 2'd1;
        3'd3: c = 2'd2;
        3'd4: c = 2'd2;
        3'd5: c = 2'd3;
        3'd6: c = 2'd3;
        3'd7: c = 2'd0;
        default: c = 2'd0;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/thick_line_quad_expander.sv */
// Top level: expands a line segment into a quad and streams its vertices.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  config   | cfg_we                | cfg_index, cfg_data (half_width, fill_mode)
//  input    | in_valid / in_ready   | start_x/y/z/color, end_x/y/z/color
//  output   | out_valid / out_ready | vert_x/y/z/color, last
//
// A segment enters the arithmetic pipeline every cycle unless it is frozen; the first
// vertex passes stages A-D, 35 root, 32 divider, corner, sequencer and out in order.
// A segment yields six vertices in fill mode and eight in outline mode through the
// single vertex output port; a zero-length segment is dropped without emitting any.
// Reset clears the stage valids, the sequencer and out_valid.
// Once stage E holds a segment, a busy sequencer or stalled output freezes the pipeline.
`default_nettype none
module thick_line_quad_expander #(
  parameter int COORD_WIDTH = tlqe_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [tlqe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tlqe_pkg::HW_W-1:0]          cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [tlqe_pkg::DATA_W-1:0] start_x,
  input  wire logic signed [tlqe_pkg::DATA_W-1:0] start_y,
  input  wire logic signed [tlqe_pkg::DATA_W-1:0] start_z,
  input  wire logic [tlqe_pkg::DATA_W-1:0]        start_color,
  input  wire logic signed [tlqe_pkg::DATA_W-1:0] end_x,
  input  wire logic signed [tlqe_pkg::DATA_W-1:0] end_y,
  input  wire logic signed [tlqe_pkg::DATA_W-1:0] end_z,
  input  wire logic [tlqe_pkg::DATA_W-1:0]        end_color,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [tlqe_pkg::DATA_W-1:0]      vert_x,
  output logic signed [tlqe_pkg::DATA_W-1:0]      vert_y,
  output logic signed [tlqe_pkg::DATA_W-1:0]      vert_z,
  output logic [tlqe_pkg::DATA_W-1:0]             vert_color,
  output logic                                    last
);

  localparam int DW_  = tlqe_pkg::DATA_W;
  localparam int HWW  = tlqe_pkg::HW_W;
  localparam int IN_W = (COORD_WIDTH < DW_) ? COORD_WIDTH : DW_;
  localparam int LW   = IN_W + 1;
  localparam int RB   = LW + 1;
  localparam int NW   = LW + HWW;
  localparam int XW   = ((COORD_WIDTH > 34) ? COORD_WIDTH : 34) + 1;

  localparam logic signed [XW-1:0] SAT_HI =
    {{(XW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO =
    {{(XW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic            zero;
    logic            sgn_x;
    logic            sgn_y;
    logic [NW-1:0]   num_x;
    logic [NW-1:0]   num_y;
    tlqe_pkg::item_t item;
  } sq_pay_t;

  typedef struct packed {
    logic            zero;
    logic            sgn_x;
    logic            sgn_y;
    tlqe_pkg::item_t item;
  } dv_pay_t;

  function automatic logic signed [XW-1:0] coord(input logic [DW_-1:0] f);
    return XW'(signed'(f[IN_W-1:0]));
  endfunction

  function automatic logic [DW_-1:0] sat32(input logic signed [XW-1:0] s);
    logic signed [XW-1:0] c;
    if (s > SAT_HI) begin
      c = SAT_HI;
    end else if (s < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = s;
    end
    return c[DW_-1:0];
  endfunction

  // configuration
  logic [HWW-1:0] half_width;
  logic           fill_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= tlqe_pkg::HW_RESET;
      fill_mode  <= tlqe_pkg::FILL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tlqe_pkg::REG_HALF_WIDTH) begin
        half_width <= cfg_data;
      end else if (cfg_index == tlqe_pkg::REG_FILL_MODE) begin
        fill_mode <= cfg_data[0];
      end
    end
  end

  logic en;
  assign in_ready = en;

  // stage A: capture
  logic            a_valid;
  tlqe_pkg::item_t a_item;
  // stage B: differences
  logic                   b_valid;
  tlqe_pkg::item_t        b_item;
  logic signed [LW-1:0]   b_dx;
  logic signed [LW-1:0]   b_dy;
  // stage C: squares and numerators
  logic            c_valid;
  tlqe_pkg::item_t c_item;
  logic [2*LW-1:0] c_sqx;
  logic [2*LW-1:0] c_sqy;
  logic [NW-1:0]   c_num_x;
  logic [NW-1:0]   c_num_y;
  logic            c_sgn_x;
  logic            c_sgn_y;
  // stage D: radicand
  logic            d_valid;
  logic [2*RB-1:0] d_rad;
  sq_pay_t         d_pay;

  logic [LW-1:0]   mag_dx;
  logic [LW-1:0]   mag_dy;
  logic [2*RB-1:0] rad_sum;

  assign mag_dx  = b_dx[LW-1] ? LW'(-b_dx) : LW'(b_dx);
  assign mag_dy  = b_dy[LW-1] ? LW'(-b_dy) : LW'(b_dy);
  assign rad_sum = (2*RB)'(c_sqx) + (2*RB)'(c_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
    if (en) begin
      a_item <= '{sx: start_x, sy: start_y, sz: start_z, sc: start_color,
                  ex: end_x, ey: end_y, ez: end_z, ec: end_color};
      b_item <= a_item;
      b_dx   <= LW'(signed'(a_item.ex[IN_W-1:0])) - LW'(signed'(a_item.sx[IN_W-1:0]));
      b_dy   <= LW'(signed'(a_item.ey[IN_W-1:0])) - LW'(signed'(a_item.sy[IN_W-1:0]));
      c_item  <= b_item;
      c_sqx   <= (2*LW)'(mag_dx) * (2*LW)'(mag_dx);
      c_sqy   <= (2*LW)'(mag_dy) * (2*LW)'(mag_dy);
      c_num_x <= NW'(mag_dy) * NW'(half_width);
      c_num_y <= NW'(mag_dx) * NW'(half_width);
      // nx follows -dy, ny follows dx
      c_sgn_x <= !b_dy[LW-1] && (b_dy != '0);
      c_sgn_y <= b_dx[LW-1];
      d_rad       <= rad_sum;
      d_pay.zero  <= (rad_sum == '0);
      d_pay.sgn_x <= c_sgn_x;
      d_pay.sgn_y <= c_sgn_y;
      d_pay.num_x <= c_num_x;
      d_pay.num_y <= c_num_y;
      d_pay.item  <= c_item;
    end
  end

  logic          sq_valid;
  logic [RB-1:0] sq_root;
  sq_pay_t       sq_pay;

  tlqe_sqrt #(
    .RB (RB),
    .PW ($bits(sq_pay_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .rad       (d_rad),
    .pay_in    (d_pay),
    .out_valid (sq_valid),
    .root      (sq_root),
    .pay_out   (sq_pay)
  );

  dv_pay_t        dv_in;
  logic           dv_valid;
  logic [HWW-1:0] q_x;
  logic [HWW-1:0] q_y;
  dv_pay_t        dv_pay;

  assign dv_in = '{zero: sq_pay.zero, sgn_x: sq_pay.sgn_x, sgn_y: sq_pay.sgn_y,
                   item: sq_pay.item};

  tlqe_div #(
    .DW (RB),
    .NW (NW),
    .QB (HWW),
    .PW ($bits(dv_pay_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .num_x     (sq_pay.num_x),
    .num_y     (sq_pay.num_y),
    .den       (sq_root),
    .pay_in    (dv_in),
    .out_valid (dv_valid),
    .q_x       (q_x),
    .q_y       (q_y),
    .pay_out   (dv_pay)
  );

  // stage E: corners, saturated
  logic signed [XW-1:0] nx;
  logic signed [XW-1:0] ny;
  logic signed [XW-1:0] psx;
  logic signed [XW-1:0] psy;
  logic signed [XW-1:0] pex;
  logic signed [XW-1:0] pey;
  logic [3:0][DW_-1:0]  cx_next;
  logic [3:0][DW_-1:0]  cy_next;

  always_comb begin
    nx  = dv_pay.sgn_x ? -XW'(q_x) : XW'(q_x);
    ny  = dv_pay.sgn_y ? -XW'(q_y) : XW'(q_y);
    psx = coord(dv_pay.item.sx);
    psy = coord(dv_pay.item.sy);
    pex = coord(dv_pay.item.ex);
    pey = coord(dv_pay.item.ey);
    cx_next[0] = sat32(psx - nx);
    cy_next[0] = sat32(psy - ny);
    cx_next[1] = sat32(psx + nx);
    cy_next[1] = sat32(psy + ny);
    cx_next[2] = sat32(pex + nx);
    cy_next[2] = sat32(pey + ny);
    cx_next[3] = sat32(pex - nx);
    cy_next[3] = sat32(pey - ny);
  end

  logic                e_valid;
  logic                e_zero;
  logic [3:0][DW_-1:0] e_x;
  logic [3:0][DW_-1:0] e_y;
  tlqe_pkg::item_t     e_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= dv_valid;
    end
    if (en) begin
      e_zero <= dv_pay.zero;
      e_x    <= cx_next;
      e_y    <= cy_next;
      e_item <= dv_pay.item;
    end
  end

  // vertex sequencer
  logic                cur_valid;
  logic                cur_fill;
  logic [2:0]          idx;
  logic [3:0][DW_-1:0] cur_x;
  logic [3:0][DW_-1:0] cur_y;
  tlqe_pkg::item_t     cur_item;

  logic       out_free;
  logic       fire;
  logic       cur_done;
  logic       take;
  logic [2:0] last_idx;
  logic [1:0] corner;

  assign out_free = !out_valid || out_ready;
  assign last_idx = cur_fill ? tlqe_pkg::FILL_LAST : tlqe_pkg::EDGE_LAST;
  assign fire     = cur_valid && out_free;
  assign cur_done = fire && (idx == last_idx);
  assign take     = !cur_valid || cur_done;
  assign en       = !e_valid || take;
  assign corner   = tlqe_pkg::seq_corner(cur_fill, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (e_valid && take) begin
        // drop zero-length segments here
        cur_valid <= !e_zero;
        idx       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (fire) begin
        idx <= idx + 3'd1;
      end
      if (out_free) begin
        out_valid <= fire;
      end
    end
    if (e_valid && take) begin
      cur_fill <= fill_mode;
      cur_x    <= e_x;
      cur_y    <= e_y;
      cur_item <= e_item;
    end
    if (fire) begin
      vert_x     <= cur_x[corner];
      vert_y     <= cur_y[corner];
      vert_z     <= corner[1] ? cur_item.ez : cur_item.sz;
      vert_color <= corner[1] ? cur_item.ec : cur_item.sc;
      last       <= (idx == last_idx);
    end
  end

endmodule
`default_nettype wire

/* sv/tlqe_sqrt.sv */
// Pipelined floor square root, one root bit per stage, with a payload carried alongside.
`default_nettype none
module tlqe_sqrt #(
  parameter int RB = 34,
  parameter int PW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*RB-1:0] rad,
  input  wire logic [PW-1:0]   pay_in,
  output logic                 out_valid,
  output logic [RB-1:0]        root,
  output logic [PW-1:0]        pay_out
);

  localparam int RRW = RB + 3;

  logic [RB:0]     v;
  logic [2*RB-1:0] rad_r  [RB+1];
  logic [RRW-1:0]  rem_r  [RB+1];
  logic [RB-1:0]   root_r [RB+1];
  logic [PW-1:0]   pay_r  [RB+1];

  logic [2*RB-1:0] rad_next  [RB];
  logic [RRW-1:0]  rem_next  [RB];
  logic [RB-1:0]   root_next [RB];
  logic [RRW-1:0]  t         [RB];
  logic [RRW-1:0]  trial     [RB];

  always_comb begin
    for (int j = 0; j < RB; j++) begin
      t[j]     = {rem_r[j][RRW-3:0], rad_r[j][2*RB-1 -: 2]};
      trial[j] = {1'b0, root_r[j], 2'b01};
      if (t[j] >= trial[j]) begin
        rem_next[j]  = t[j] - trial[j];
        root_next[j] = {root_r[j][RB-2:0], 1'b1};
      end else begin
        rem_next[j]  = t[j];
        root_next[j] = {root_r[j][RB-2:0], 1'b0};
      end
      rad_next[j] = {rad_r[j][2*RB-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[RB-1:0], in_valid};
    end
    if (en) begin
      rad_r[0]  <= rad;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      pay_r[0]  <= pay_in;
      for (int j = 0; j < RB; j++) begin
        rad_r[j+1]  <= rad_next[j];
        rem_r[j+1]  <= rem_next[j];
        root_r[j+1] <= root_next[j];
        pay_r[j+1]  <= pay_r[j];
      end
    end
  end

  assign out_valid = v[RB];
  assign root      = root_r[RB];
  assign pay_out   = pay_r[RB];

endmodule
`default_nettype wire

/* sv/tlqe_div.sv */
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
`default_nettype none
module tlqe_div #(
  parameter int DW = 34,
  parameter int NW = 64,
  parameter int QB = tlqe_pkg::HW_W,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num_x,
  input  wire logic [NW-1:0] num_y,
  input  wire logic [DW-1:0] den,
  input  wire logic [PW-1:0] pay_in,
  output logic               out_valid,
  output logic [QB-1:0]      q_x,
  output logic [QB-1:0]      q_y,
  output logic [PW-1:0]      pay_out
);

  logic [QB:0]     v;
  logic [DW-1:0]   rx_r  [QB+1];
  logic [DW-1:0]   ry_r  [QB+1];
  logic [QB-1:0]   nbx_r [QB+1];
  logic [QB-1:0]   nby_r [QB+1];
  logic [QB-1:0]   qx_r  [QB+1];
  logic [QB-1:0]   qy_r  [QB+1];
  logic [DW-1:0]   den_r [QB+1];
  logic [PW-1:0]   pay_r [QB+1];

  logic [DW:0] stx [QB];
  logic [DW:0] sty [QB];

  function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                           input logic [DW-1:0] d);
    logic [DW:0] t;
    logic [DW:0] dd;
    t  = {r, b};
    dd = {1'b0, d};
    if (t >= dd) begin
      return {1'b1, DW'(t - dd)};
    end
    return {1'b0, t[DW-1:0]};
  endfunction

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      stx[j] = div_step(rx_r[j], nbx_r[j][QB-1], den_r[j]);
      sty[j] = div_step(ry_r[j], nby_r[j][QB-1], den_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QB-1:0], in_valid};
    end
    if (en) begin
      // upper numerator bits stay below the divisor since the quotient fits QB bits
      rx_r[0]  <= DW'(num_x[NW-1:QB]);
      ry_r[0]  <= DW'(num_y[NW-1:QB]);
      nbx_r[0] <= num_x[QB-1:0];
      nby_r[0] <= num_y[QB-1:0];
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      den_r[0] <= den;
      pay_r[0] <= pay_in;
      for (int j = 0; j < QB; j++) begin
        rx_r[j+1]  <= stx[j][DW-1:0];
        ry_r[j+1]  <= sty[j][DW-1:0];
        nbx_r[j+1] <= {nbx_r[j][QB-2:0], 1'b0};
        nby_r[j+1] <= {nby_r[j][QB-2:0], 1'b0};
        qx_r[j+1]  <= {qx_r[j][QB-2:0], stx[j][DW]};
        qy_r[j+1]  <= {qy_r[j][QB-2:0], sty[j][DW]};
        den_r[j+1] <= den_r[j];
        pay_r[j+1] <= pay_r[j];
      end
    end
  end

  assign out_valid = v[QB];
  assign q_x       = qx_r[QB];
  assign q_y       = qy_r[QB];
  assign pay_out   = pay_r[QB];

endmodule
`default_nettype wire
